// ----- design/aprow_pkg.sv -----
// ----------------------------------------------------------------------------
// aprow_pkg: shared types and constants for the int8 average pool row block
//
// Field widths, configuration register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package aprow_pkg;

    // Pixel layout: 16 signed byte channels
    localparam int LANES  = 16;
    localparam int LANE_W = 8;
    localparam int DATA_W = LANES * LANE_W;

    // Configuration register widths
    localparam int KW_W       = 7;
    localparam int KH_W       = 4;
    localparam int STRIDE_W   = 7;
    localparam int IW_W       = 7;
    localparam int OW_W       = 7;
    localparam int SCALE_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SCALE_W;

    // Fixed-point result position inside the wrapped product
    localparam int RES_SHIFT = 24;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1 << RES_SHIFT);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR  = 3'd5;

    // Controller states
    typedef enum logic [1:0] {
        S_LOAD,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_en;     // store the incoming pixel, advance the load count
        logic start_band;  // reset window counters, sums and error flag
        logic read_en;     // read one window pixel, advance x and y
        logic next_win;    // move to the next output window
        logic push_en;     // scale the sums into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic band_done;   // the pixel being offered completes the band
        logic x_last;      // last column of the window
        logic y_last;      // last row of the window
        logic ox_last;     // last output window of the band
        logic kw_zero;     // empty window, no reads
        logic out_free;    // output register can take a new item
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/aprow_ctrl.sv -----
// ----------------------------------------------------------------------------
// aprow_ctrl: sequencer for band load, window reads and result emission
//
// Loads pixels until the band is complete, then walks every output window
// row by row, drains the read pipeline and pushes each result.
// ----------------------------------------------------------------------------
`default_nettype none

module aprow_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  aprow_pkg::t_dp_stat i_stat,
    output aprow_pkg::t_dp_cmd  o_cmd
);
    import aprow_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load_en = i_in_valid;
                if (i_in_valid && i_stat.band_done) begin
                    o_cmd.start_band = 1'b1;
                    n_state = i_stat.kw_zero ? S_EMIT : S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_en = 1'b1;
                if (i_stat.x_last && i_stat.y_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // let the last read land in the sums
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.push_en = 1'b1;
                    if (i_stat.ox_last) begin
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.next_win = 1'b1;
                        n_state = i_stat.kw_zero ? S_EMIT : S_READ;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

`ifndef SYNTH
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_en, o_cmd.read_en, o_cmd.push_en}))
        else $error("load, read and push commands overlap");

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push_en |-> i_stat.out_free)
        else $error("push issued while output register is occupied");

    a_band_end_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.push_en && i_stat.ox_last) |=> (r_state == S_LOAD))
        else $error("controller did not return to load after last window");
`endif

endmodule

`default_nettype wire

// ----- design/aprow_dp.sv -----
// ----------------------------------------------------------------------------
// aprow_dp: pixel store, window walk, channel sums and scaling
//
// Holds the configuration registers, the band store, the window address
// counters, 16 lane accumulators, the scale multipliers and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module aprow_dp #(
    parameter int MAX_KERNEL_HEIGHT = 8,
    parameter int MAX_INPUT_WIDTH   = 64,
    parameter int MAX_OUTPUT_WIDTH  = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [aprow_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire  [aprow_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire  [aprow_pkg::DATA_W-1:0]        i_in_data,
    input  aprow_pkg::t_dp_cmd                  i_cmd,
    output aprow_pkg::t_dp_stat                 o_stat,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [aprow_pkg::DATA_W-1:0]        o_out_data,
    output logic                                o_out_last,
    output logic                                o_out_err
);
    import aprow_pkg::*;

    localparam int STORE_PIXELS = MAX_KERNEL_HEIGHT * MAX_INPUT_WIDTH;
    localparam int ADDR_W = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
    localparam int BAND_W = $clog2(STORE_PIXELS + 1);
    localparam int IDX_W  = $clog2((MAX_OUTPUT_WIDTH + MAX_KERNEL_HEIGHT + 1) * 128
                                   + STORE_PIXELS);
    // worst case channel sum: MAX_KERNEL_HEIGHT rows by 127 columns of -128
    localparam int SUM_W  = $clog2(MAX_KERNEL_HEIGHT * 127 * 128) + 1;
    localparam int PROD_W = SUM_W + SCALE_W + 1;

    // Configuration registers
    logic [KW_W-1:0]     r_kw;
    logic [KH_W-1:0]     r_kh;
    logic [STRIDE_W-1:0] r_stride;
    logic [IW_W-1:0]     r_iw;
    logic [OW_W-1:0]     r_ow;
    logic [SCALE_W-1:0]  r_scale;

    // Clamped geometry
    logic [KH_W-1:0]      kh_c;
    logic [IW_W-1:0]      iw_c;
    logic [OW_W-1:0]      ow_c;
    logic [KH_W+IW_W-1:0] band_full;
    logic [BAND_W-1:0]    band;
    logic [BAND_W:0]      load_next;
    logic                 idx_in_range;

    // Band store and load counter
    logic [DATA_W-1:0] r_mem [STORE_PIXELS];
    logic [BAND_W-1:0] r_load_cnt;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_valid;

    // Window walk
    logic [OW_W-1:0]  r_ox,  n_ox;
    logic [KH_W-1:0]  r_y,   n_y;
    logic [KW_W-1:0]  r_x,   n_x;
    logic [IDX_W-1:0] r_win, n_win;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_err, n_err;

    // Channel sums and scaled bytes
    logic signed [SUM_W-1:0]  r_sum [LANES];
    logic signed [SUM_W-1:0]  n_sum [LANES];
    logic signed [PROD_W-1:0] prod  [LANES];
    logic [DATA_W-1:0]        n_res;

    // Output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic              r_out_err;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw     <= KW_W'(1);
            r_kh     <= KH_W'(1);
            r_stride <= STRIDE_W'(1);
            r_iw     <= IW_W'(1);
            r_ow     <= OW_W'(1);
            r_scale  <= SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_KERNEL_WIDTH:  r_kw     <= i_cfg_wdata[KW_W-1:0];
                CFG_KERNEL_HEIGHT: r_kh     <= i_cfg_wdata[KH_W-1:0];
                CFG_STRIDE_X:      r_stride <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_INPUT_WIDTH:   r_iw     <= i_cfg_wdata[IW_W-1:0];
                CFG_OUTPUT_WIDTH:  r_ow     <= i_cfg_wdata[OW_W-1:0];
                CFG_SCALE_FACTOR:  r_scale  <= i_cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp height, row width and output count into their legal ranges
    always_comb begin
        if (r_kh == '0) begin
            kh_c = KH_W'(1);
        end else if (int'(r_kh) > MAX_KERNEL_HEIGHT) begin
            kh_c = KH_W'(MAX_KERNEL_HEIGHT);
        end else begin
            kh_c = r_kh;
        end
        if (r_iw == '0) begin
            iw_c = IW_W'(1);
        end else if (int'(r_iw) > MAX_INPUT_WIDTH) begin
            iw_c = IW_W'(MAX_INPUT_WIDTH);
        end else begin
            iw_c = r_iw;
        end
        if (r_ow == '0) begin
            ow_c = OW_W'(1);
        end else if (int'(r_ow) > MAX_OUTPUT_WIDTH) begin
            ow_c = OW_W'(MAX_OUTPUT_WIDTH);
        end else begin
            ow_c = r_ow;
        end
    end

    assign band_full    = kh_c * iw_c;
    assign band         = BAND_W'(band_full);
    assign load_next    = {1'b0, r_load_cnt} + (BAND_W + 1)'(1);
    assign idx_in_range = (r_idx < IDX_W'(band));

    // Status to the controller
    assign o_stat.band_done = (load_next >= {1'b0, band});
    assign o_stat.x_last    = (r_x == r_kw - KW_W'(1));
    assign o_stat.y_last    = (r_y == kh_c - KH_W'(1));
    assign o_stat.ox_last   = (r_ox == ow_c - OW_W'(1));
    assign o_stat.kw_zero   = (r_kw == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Count loaded pixels, restart when the band completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (i_cmd.load_en) begin
            r_load_cnt <= o_stat.band_done ? '0 : load_next[BAND_W-1:0];
        end
    end

    // Store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_mem[r_load_cnt[ADDR_W-1:0]] <= i_in_data;
        end
    end

    // Store read, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_en) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.read_en && idx_in_range;
        end
    end

    // Walk the window and accumulate channels
    always_comb begin
        n_ox  = r_ox;
        n_y   = r_y;
        n_x   = r_x;
        n_win = r_win;
        n_row = r_row;
        n_idx = r_idx;
        n_err = r_err;
        n_sum = r_sum;
        if (i_cmd.start_band) begin
            n_ox  = '0;
            n_y   = '0;
            n_x   = '0;
            n_win = '0;
            n_row = '0;
            n_idx = '0;
            n_err = 1'b0;
            for (int l = 0; l < LANES; l++) begin
                n_sum[l] = '0;
            end
        end else if (i_cmd.next_win) begin
            n_ox  = r_ox + OW_W'(1);
            n_y   = '0;
            n_x   = '0;
            n_win = r_win + IDX_W'(r_stride);
            n_row = n_win;
            n_idx = n_win;
            n_err = 1'b0;
            for (int l = 0; l < LANES; l++) begin
                n_sum[l] = '0;
            end
        end else begin
            if (i_cmd.read_en) begin
                // a pixel beyond the band adds nothing and flags the window
                if (!idx_in_range) begin
                    n_err = 1'b1;
                end
                if (o_stat.x_last) begin
                    n_x   = '0;
                    n_y   = r_y + KH_W'(1);
                    n_row = r_row + IDX_W'(iw_c);
                    n_idx = n_row;
                end else begin
                    n_x   = r_x + KW_W'(1);
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            if (r_rd_valid) begin
                for (int l = 0; l < LANES; l++) begin
                    n_sum[l] = r_sum[l]
                             + SUM_W'($signed(r_rd_data[l*LANE_W +: LANE_W]));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ox  <= n_ox;
        r_y   <= n_y;
        r_x   <= n_x;
        r_win <= n_win;
        r_row <= n_row;
        r_idx <= n_idx;
        r_err <= n_err;
        r_sum <= n_sum;
    end

    // Scale each channel sum: wrapped product, arithmetic shift, low byte
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            prod[l] = r_sum[l] * $signed({1'b0, r_scale});
            n_res[l*LANE_W +: LANE_W] = prod[l][RES_SHIFT +: LANE_W];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_en) begin
            r_out_data <= n_res;
            r_out_last <= o_stat.ox_last;
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_err   = r_out_err;

`ifndef SYNTH
    a_rd_valid_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> $past(i_cmd.read_en))
        else $error("read data marked valid without a read");

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_en && o_stat.band_done) |=> (r_load_cnt == '0))
        else $error("load count did not restart after band completion");

    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_en |=> r_out_valid)
        else $error("pushed result not presented");
`endif

endmodule

`default_nettype wire

// ----- design/int8_average_pool_row.sv -----
// ----------------------------------------------------------------------------
// int8_average_pool_row: int8 average pooling over one loaded band of rows
//
// Pixels of 16 signed byte channels are loaded one per cycle until
// kernel_height rows of input_width pixels are in the store. The band then
// produces output_width results, each the scaled channel sums of one
// kernel_height by kernel_width window. Input is not taken while the band is
// being emitted. For each result the block reads every window pixel in turn
// from the single-read-port pixel store, drains the read pipeline and then
// scales the sums into the output register (only the scaling step when
// kernel_width is zero); the output side can stall the scaling step. A result
// can wait in the output register while the next window is already being
// summed.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_average_pool_row #(
    parameter int MAX_KERNEL_HEIGHT = 8,
    parameter int MAX_INPUT_WIDTH   = 64,
    parameter int MAX_OUTPUT_WIDTH  = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write port
    input  wire                              i_cfg_wr_en,
    input  wire  [aprow_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire  [aprow_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel input
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [aprow_pkg::DATA_W-1:0]     s_axis_tdata,  // lanes_low, lanes_high
    // pooled output
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [aprow_pkg::DATA_W-1:0]     m_axis_tdata,  // result_low, result_high
    output logic                             m_axis_tlast,  // last
    output logic                             m_axis_tuser   // window_error
);
    import aprow_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    aprow_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    aprow_dp #(
        .MAX_KERNEL_HEIGHT (MAX_KERNEL_HEIGHT),
        .MAX_INPUT_WIDTH   (MAX_INPUT_WIDTH),
        .MAX_OUTPUT_WIDTH  (MAX_OUTPUT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_err   (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- sim/int8_average_pool_row_tb.sv -----
// ----------------------------------------------------------------------------
// int8_average_pool_row_tb: self-checking bench for the int8 average pool row
//
// Loads bands of 16-channel pixels under a range of window, stride, width and
// scale settings, including out-of-range register values and a band that
// shrinks during its load. A local pooling predictor computes every pooled
// item, and each output item is compared field by field in arrival order.
// Both stream sides idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------

module int8_average_pool_row_tb;

    import aprow_pkg::*;

    localparam int MAX_KH      = 8;
    localparam int MAX_IW      = 64;
    localparam int MAX_OW      = 64;
    localparam int STORE_PIX   = MAX_KH * MAX_IW;
    localparam int STALL_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [DATA_W-1:0] avg;
        logic              last;
        logic              win_err;
    } t_pooled;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;  // lanes_low, lanes_high
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;       // result_low, result_high
    logic                  m_axis_tlast;       // last
    logic                  m_axis_tuser;       // window_error

    // Pixels waiting to be sent, pooled items waiting to arrive
    logic [DATA_W-1:0] pixel_q[$];
    t_pooled           pooled_q[$];

    // Predictor copy of the registers and the band store
    logic [KW_W-1:0]     cfg_kw = KW_W'(1);
    logic [KH_W-1:0]     cfg_kh = KH_W'(1);
    logic [STRIDE_W-1:0] cfg_stride = STRIDE_W'(1);
    logic [IW_W-1:0]     cfg_iw = IW_W'(1);
    logic [OW_W-1:0]     cfg_ow = OW_W'(1);
    logic [SCALE_W-1:0]  cfg_scale = SCALE_RESET;
    logic [DATA_W-1:0]   band_pix [STORE_PIX];
    int unsigned         loaded = 0;

    int  mismatch_count = 0;
    int  drv_gap = 0;
    int  rdy_gap = 0;
    int  stall_cycles = 0;
    bit  gaps_on = 1'b1;

    int8_average_pool_row #(
        .MAX_KERNEL_HEIGHT (MAX_KH),
        .MAX_INPUT_WIDTH   (MAX_IW),
        .MAX_OUTPUT_WIDTH  (MAX_OW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Store one pixel; on the band's last pixel, pool every output window
    function automatic void pool_pixel(logic [DATA_W-1:0] pix);
        int unsigned kh, iw, ow, band, idx, ox, x, y, c;
        int          sums [LANES];
        logic [31:0] prod;
        t_pooled     res;
        kh   = clamp(32'(cfg_kh), MAX_KH);
        iw   = clamp(32'(cfg_iw), MAX_IW);
        ow   = clamp(32'(cfg_ow), MAX_OW);
        band = kh * iw;
        if (loaded < STORE_PIX) band_pix[loaded] = pix;
        loaded++;
        if (loaded < band) return;
        for (ox = 0; ox < ow; ox++) begin
            res.avg     = '0;
            res.win_err = 1'b0;
            res.last    = (ox + 1 == ow);
            for (c = 0; c < LANES; c++) sums[c] = 0;
            for (y = 0; y < kh; y++) begin
                for (x = 0; x < cfg_kw; x++) begin
                    idx = ox * cfg_stride + x + iw * y;
                    // past the loaded band: add nothing, flag the window
                    if (idx >= band) begin
                        res.win_err = 1'b1;
                    end else begin
                        for (c = 0; c < LANES; c++)
                            sums[c] += $signed(band_pix[idx][c*LANE_W +: LANE_W]);
                    end
                end
            end
            // wrap the product to 32 bits, keep bits 31..24
            for (c = 0; c < LANES; c++) begin
                prod = 32'(sums[c]) * {7'd0, cfg_scale};
                res.avg[c*LANE_W +: LANE_W] = prod[RES_SHIFT +: LANE_W];
            end
            pooled_q.push_back(res);
        end
        loaded = 0;
    endfunction

    function automatic void flag(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endfunction

    // Pixel driver: hold until taken, insert random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) pool_pixel(s_axis_tdata);
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the offered item
            end else if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (gaps_on && $urandom_range(5, 0) == 0) begin
                drv_gap <= $urandom_range(13, 0);
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pixel_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: check each taken item against the oldest prediction
    always @(posedge i_clk) begin
        t_pooled want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rdy_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pooled_q.size() == 0) begin
                    flag("unexpected item", '0, m_axis_tdata[63:0]);
                end else begin
                    want = pooled_q.pop_front();
                    if (m_axis_tdata[63:0] !== want.avg[63:0])
                        flag("result_low", want.avg[63:0], m_axis_tdata[63:0]);
                    if (m_axis_tdata[127:64] !== want.avg[127:64])
                        flag("result_high", want.avg[127:64], m_axis_tdata[127:64]);
                    if (m_axis_tlast !== want.last)
                        flag("last", 64'(want.last), 64'(m_axis_tlast));
                    if (m_axis_tuser !== want.win_err)
                        flag("window_error", 64'(want.win_err), 64'(m_axis_tuser));
                end
            end
            if (rdy_gap > 0) begin
                rdy_gap <= rdy_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(5, 0) == 0) begin
                rdy_gap <= $urandom_range(13, 0);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_KERNEL_WIDTH:  cfg_kw     = val[KW_W-1:0];
            CFG_KERNEL_HEIGHT: cfg_kh     = val[KH_W-1:0];
            CFG_STRIDE_X:      cfg_stride = val[STRIDE_W-1:0];
            CFG_INPUT_WIDTH:   cfg_iw     = val[IW_W-1:0];
            CFG_OUTPUT_WIDTH:  cfg_ow     = val[OW_W-1:0];
            CFG_SCALE_FACTOR:  cfg_scale  = val[SCALE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(int kw, int kh, int stride, int iw, int ow, int scale);
        write_reg(CFG_KERNEL_WIDTH, CFG_DATA_W'(kw));
        write_reg(CFG_KERNEL_HEIGHT, CFG_DATA_W'(kh));
        write_reg(CFG_STRIDE_X, CFG_DATA_W'(stride));
        write_reg(CFG_INPUT_WIDTH, CFG_DATA_W'(iw));
        write_reg(CFG_OUTPUT_WIDTH, CFG_DATA_W'(ow));
        write_reg(CFG_SCALE_FACTOR, CFG_DATA_W'(scale));
    endtask

    // Wait until every pixel is taken and every pooled item has arrived
    task automatic settle();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || pooled_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_pixel();
        case ($urandom_range(9, 0))
            0:       return {LANES{8'h80}};
            1:       return {LANES{8'h7F}};
            default: return {$urandom(), $urandom(), $urandom(), $urandom()};
        endcase
    endfunction

    initial begin
        int rand_items;
        int kw, kh, stride, iw, ow, scale, band, n;
        rand_items = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings pass pixels straight through: lane extremes
        pixel_q.push_back({LANES{8'h00}});
        pixel_q.push_back({LANES{8'hFF}});
        pixel_q.push_back({LANES{8'h80}});
        pixel_q.push_back({LANES{8'h7F}});
        pixel_q.push_back({(LANES/2){8'h7F, 8'h80}});
        settle();

        // All-zero registers: clamped sizes, empty window
        write_all(0, 0, 0, 0, 0, 0);
        pixel_q.push_back({$urandom(), $urandom(), $urandom(), $urandom()});
        settle();

        // Height above the limit, windows past the band, wrapping product
        write_all(3, 15, 127, 2, 3, 32'h01FF_FFFF);
        for (int i = 0; i < 16; i++)
            pixel_q.push_back(i[0] ? {LANES{8'h80}} : {LANES{8'h7F}});
        settle();

        // Band shrinks below the loaded count: next pixel emits at once
        write_all(2, 1, 1, 4, 2, 1 << 23);
        pixel_q.push_back(rand_pixel());
        pixel_q.push_back(rand_pixel());
        settle();
        write_reg(CFG_INPUT_WIDTH, CFG_DATA_W'(1));
        pixel_q.push_back(rand_pixel());
        settle();

        // Count the pixels sent by the directed cases above
        rand_items = 25;

        // Random settings, mostly small bands, a few at the register extremes
        while (rand_items < 160) begin
            gaps_on = (rand_items < 120) && ($urandom_range(3, 0) != 0);
            kh     = ($urandom_range(7, 0) == 0) ? $urandom_range(15, 8) : $urandom_range(3, 0);
            iw     = ($urandom_range(7, 0) == 0) ? $urandom_range(127, 60) : $urandom_range(8, 0);
            kw     = ($urandom_range(7, 0) == 0) ? $urandom_range(127, 60) : $urandom_range(6, 0);
            stride = ($urandom_range(7, 0) == 0) ? 127 : $urandom_range(4, 0);
            ow     = ($urandom_range(7, 0) == 0) ? $urandom_range(127, 60) : $urandom_range(8, 0);
            if (clamp(kh, MAX_KH) * clamp(iw, MAX_IW) > 64) kh = 1;
            band = clamp(kh, MAX_KH) * clamp(iw, MAX_IW);
            case ($urandom_range(3, 0))
                0:       scale = 0;
                1:       scale = 32'h01FF_FFFF;
                2:       scale = $urandom_range(32'h01FF_FFFF, 0);
                default: scale = (1 << RES_SHIFT) / (clamp(kh, MAX_KH) * (kw == 0 ? 1 : kw));
            endcase
            write_all(kw, kh, stride, iw, ow, scale);
            n = band * $urandom_range(3, 1);
            // sometimes leave a part-loaded band for the next setting
            if (band > 1 && $urandom_range(3, 0) == 0) n += $urandom_range(band - 1, 1);
            // keep the total pixel count near the run length
            if (n > 160 - rand_items) n = 160 - rand_items;
            for (int i = 0; i < n; i++) pixel_q.push_back(rand_pixel());
            rand_items += n;
            settle();
        end

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pooled_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/aprow_pkg.sv
design/aprow_ctrl.sv
design/aprow_dp.sv
design/int8_average_pool_row.sv
sim/int8_average_pool_row_tb.sv
